/* hw/rtl/assert_macros.svh */
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication failed");

`endif

/* hw/rtl/tcc_pkg.sv */
// types and constants of the tetrahedron circumcenter pipeline
package tcc_pkg;

    localparam int CoordBits = 20;
    localparam int EdgeBits  = CoordBits + 1;
    localparam int CofBits   = 2 * EdgeBits + 1;
    localparam int RhsBits   = 2 * EdgeBits;
    localparam int HalfBits  = EdgeBits;
    localparam int PartBits  = HalfBits + 1 + CofBits;
    localparam int DetPBits  = EdgeBits + CofBits;
    localparam int NumBits   = RhsBits + CofBits + 2;
    localparam int DetBits   = EdgeBits + CofBits + 2;
    localparam int DivBits   = NumBits + 1;
    localparam int DenBits   = DetBits + 1;
    localparam int QuoBits   = CoordBits + 1;

    typedef logic [1:0] t_status;
    localparam t_status StatusOk         = 2'd0;
    localparam t_status StatusDegenerate = 2'd1;
    localparam t_status StatusOverflow   = 2'd2;

    typedef struct packed {
        logic [CoordBits-1:0] v0_x;
        logic [CoordBits-1:0] v0_y;
        logic [CoordBits-1:0] v0_z;
        logic [CoordBits-1:0] v1_x;
        logic [CoordBits-1:0] v1_y;
        logic [CoordBits-1:0] v1_z;
        logic [CoordBits-1:0] v2_x;
        logic [CoordBits-1:0] v2_y;
        logic [CoordBits-1:0] v2_z;
        logic [CoordBits-1:0] v3_x;
        logic [CoordBits-1:0] v3_y;
        logic [CoordBits-1:0] v3_z;
    } t_in;

    typedef struct packed {
        logic [CoordBits-1:0] center_x;
        logic [CoordBits-1:0] center_y;
        logic [CoordBits-1:0] center_z;
        t_status              status;
    } t_out;

    // cofactors and right-hand side out of the front stages
    typedef struct packed {
        logic                           valid;
        logic [8:0][CofBits-1:0]        cof;
        logic [2:0][RhsBits-1:0]        rhs;
        logic [2:0][EdgeBits-1:0]       row0;
        logic [2:0][CoordBits-1:0]      v0;
    } t_front;

    // dividend and divisor per axis into the divider
    typedef struct packed {
        logic                           valid;
        logic                           degen;
        logic [2:0]                     neg;
        logic [2:0][DivBits-1:0]        num;
        logic [DenBits-1:0]             den;
        logic [2:0][CoordBits-1:0]      v0;
    } t_adj;

    // quotients and flags out of the divider
    typedef struct packed {
        logic                           valid;
        logic                           degen;
        logic [2:0]                     neg;
        logic [2:0]                     big;
        logic [2:0][QuoBits-1:0]        quo;
        logic [2:0][CoordBits-1:0]      v0;
    } t_dout;

    function automatic int nxt3(input int k);
        return (k == 2) ? 0 : k + 1;
    endfunction

endpackage

/* hw/rtl/tcc_front.sv */
// edge vectors, pairwise products, cofactors and squared edge lengths
module tcc_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  tcc_pkg::t_in    i_item,
    output tcc_pkg::t_front o_front
);

    localparam int C = tcc_pkg::CoordBits;
    localparam int E = tcc_pkg::EdgeBits;

    logic [C-1:0] w_vtx [4][3];

    logic                r1_valid;
    logic [8:0][E-1:0]   r1_e;
    logic [2:0][C-1:0]   r1_v0;
    logic [8:0][E-1:0]   n1_e;

    logic                r2_valid;
    logic [8:0][2*E-1:0] r2_sq;
    logic [8:0][2*E-1:0] r2_pa;
    logic [8:0][2*E-1:0] r2_pb;
    logic [2:0][E-1:0]   r2_row0;
    logic [2:0][C-1:0]   r2_v0;
    logic [8:0][2*E-1:0] n2_sq;
    logic [8:0][2*E-1:0] n2_pa;
    logic [8:0][2*E-1:0] n2_pb;

    tcc_pkg::t_front     r3_front;
    tcc_pkg::t_front     n3_front;

    assign w_vtx[0][0] = i_item.v0_x;
    assign w_vtx[0][1] = i_item.v0_y;
    assign w_vtx[0][2] = i_item.v0_z;
    assign w_vtx[1][0] = i_item.v1_x;
    assign w_vtx[1][1] = i_item.v1_y;
    assign w_vtx[1][2] = i_item.v1_z;
    assign w_vtx[2][0] = i_item.v2_x;
    assign w_vtx[2][1] = i_item.v2_y;
    assign w_vtx[2][2] = i_item.v2_z;
    assign w_vtx[3][0] = i_item.v3_x;
    assign w_vtx[3][1] = i_item.v3_y;
    assign w_vtx[3][2] = i_item.v3_z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n1_e[3*i+j] = {w_vtx[i+1][j][C-1], w_vtx[i+1][j]}
                            - {w_vtx[0][j][C-1], w_vtx[0][j]};
            end
        end
    end

    // cyclic index form gives signed cofactors directly
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n2_sq[3*i+j] = $signed(r1_e[3*i+j]) * $signed(r1_e[3*i+j]);
                n2_pa[3*i+j] = $signed(r1_e[3*tcc_pkg::nxt3(i) + tcc_pkg::nxt3(j)])
                    * $signed(r1_e[3*tcc_pkg::nxt3(tcc_pkg::nxt3(i))
                                   + tcc_pkg::nxt3(tcc_pkg::nxt3(j))]);
                n2_pb[3*i+j] = $signed(r1_e[3*tcc_pkg::nxt3(i)
                                   + tcc_pkg::nxt3(tcc_pkg::nxt3(j))])
                    * $signed(r1_e[3*tcc_pkg::nxt3(tcc_pkg::nxt3(i)) + tcc_pkg::nxt3(j)]);
            end
        end
    end

    always_comb begin
        n3_front       = '0;
        n3_front.valid = r2_valid;
        n3_front.row0  = r2_row0;
        n3_front.v0    = r2_v0;
        for (int k = 0; k < 9; k++) begin
            n3_front.cof[k] = {r2_pa[k][2*E-1], r2_pa[k]} - {r2_pb[k][2*E-1], r2_pb[k]};
        end
        for (int i = 0; i < 3; i++) begin
            n3_front.rhs[i] = r2_sq[3*i] + r2_sq[3*i+1] + r2_sq[3*i+2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid       <= 1'b0;
            r2_valid       <= 1'b0;
            r3_front.valid <= 1'b0;
        end else begin
            r1_valid       <= i_valid;
            r2_valid       <= r1_valid;
            r3_front.valid <= n3_front.valid;
        end
        r1_e             <= n1_e;
        r1_v0            <= {w_vtx[0][2], w_vtx[0][1], w_vtx[0][0]};
        r2_sq            <= n2_sq;
        r2_pa            <= n2_pa;
        r2_pb            <= n2_pb;
        r2_row0          <= {r1_e[2], r1_e[1], r1_e[0]};
        r2_v0            <= r1_v0;
        r3_front.cof     <= n3_front.cof;
        r3_front.rhs     <= n3_front.rhs;
        r3_front.row0    <= n3_front.row0;
        r3_front.v0      <= n3_front.v0;
    end

    assign o_front = r3_front;

endmodule

/* hw/rtl/tcc_adj.sv */
// numerators and determinant from cofactors, then magnitudes for the divider
module tcc_adj (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tcc_pkg::t_front i_front,
    output tcc_pkg::t_adj   o_adj
);

    localparam int H  = tcc_pkg::HalfBits;
    localparam int PW = tcc_pkg::PartBits;
    localparam int DP = tcc_pkg::DetPBits;
    localparam int NW = tcc_pkg::NumBits;
    localparam int DW = tcc_pkg::DetBits;
    localparam int C  = tcc_pkg::CoordBits;

    logic               r4_valid;
    logic [8:0][PW-1:0] r4_plo;
    logic [8:0][PW-1:0] r4_phi;
    logic [2:0][DP-1:0] r4_dp;
    logic [2:0][C-1:0]  r4_v0;
    logic [8:0][PW-1:0] n4_plo;
    logic [8:0][PW-1:0] n4_phi;
    logic [2:0][DP-1:0] n4_dp;

    logic               r5_valid;
    logic [2:0][NW-1:0] r5_num;
    logic [DW-1:0]      r5_det;
    logic [2:0][C-1:0]  r5_v0;
    logic [2:0][NW-1:0] n5_num;
    logic [DW-1:0]      n5_det;

    tcc_pkg::t_adj      r6_adj;
    tcc_pkg::t_adj      n6_adj;
    logic [NW-1:0]      w_anum [3];
    logic [DW-1:0]      w_adet;

    // rhs split in halves keeps each product at 22 by 43 bits
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n4_plo[3*i+j] = $signed({1'b0, i_front.rhs[i][H-1:0]})
                              * $signed(i_front.cof[3*i+j]);
                n4_phi[3*i+j] = $signed({1'b0, i_front.rhs[i][2*H-1:H]})
                              * $signed(i_front.cof[3*i+j]);
            end
            n4_dp[i] = $signed(i_front.row0[i]) * $signed(i_front.cof[i]);
        end
    end

    always_comb begin
        n5_det = DW'($signed(r4_dp[0])) + DW'($signed(r4_dp[1])) + DW'($signed(r4_dp[2]));
        for (int j = 0; j < 3; j++) begin
            n5_num[j] = '0;
            for (int i = 0; i < 3; i++) begin
                n5_num[j] = n5_num[j] + (NW'($signed(r4_phi[3*i+j])) << H)
                          + NW'($signed(r4_plo[3*i+j]));
            end
        end
    end

    always_comb begin
        w_adet       = r5_det[DW-1] ? (~r5_det + 1'b1) : r5_det;
        n6_adj       = '0;
        n6_adj.valid = r5_valid;
        n6_adj.degen = (r5_det == '0);
        n6_adj.den   = {w_adet, 1'b0};
        n6_adj.v0    = r5_v0;
        for (int j = 0; j < 3; j++) begin
            w_anum[j]      = r5_num[j][NW-1] ? (~r5_num[j] + 1'b1) : r5_num[j];
            n6_adj.neg[j]  = r5_num[j][NW-1] ^ r5_det[DW-1];
            n6_adj.num[j]  = {w_anum[j], 1'b0} + (NW + 1)'(w_adet);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid     <= 1'b0;
            r5_valid     <= 1'b0;
            r6_adj.valid <= 1'b0;
        end else begin
            r4_valid     <= i_front.valid;
            r5_valid     <= r4_valid;
            r6_adj.valid <= n6_adj.valid;
        end
        r4_plo       <= n4_plo;
        r4_phi       <= n4_phi;
        r4_dp        <= n4_dp;
        r4_v0        <= i_front.v0;
        r5_num       <= n5_num;
        r5_det       <= n5_det;
        r5_v0        <= r4_v0;
        r6_adj.degen <= n6_adj.degen;
        r6_adj.neg   <= n6_adj.neg;
        r6_adj.num   <= n6_adj.num;
        r6_adj.den   <= n6_adj.den;
        r6_adj.v0    <= n6_adj.v0;
    end

    assign o_adj = r6_adj;

endmodule

/* hw/rtl/tcc_div.sv */
// pipelined restoring divider, one quotient bit per stage, three axes abreast
module tcc_div (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tcc_pkg::t_adj  i_adj,
    output tcc_pkg::t_dout o_dout
);

    localparam int QB = tcc_pkg::QuoBits;
    localparam int VW = tcc_pkg::DivBits;
    localparam int DN = tcc_pkg::DenBits;
    localparam int C  = tcc_pkg::CoordBits;

    logic [QB:0]                 r_valid;
    logic [QB:0]                 r_degen;
    logic [QB:0][2:0]            r_neg;
    logic [QB:0][2:0]            r_big;
    logic [QB:0][DN-1:0]         r_den;
    logic [QB:0][2:0][C-1:0]     r_v0;
    logic [QB:0][2:0][VW-1:0]    r_rem;
    logic [QB:0][2:0][QB-1:0]    r_quo;
    logic [2:0]                  n_big;

    // quotient past QB bits means the center saturates whatever vertex 0 is
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            n_big[j] = (i_adj.num[j] >> QB) >= VW'(i_adj.den);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else begin
            r_valid[0] <= i_adj.valid;
        end
        r_degen[0] <= i_adj.degen;
        r_neg[0]   <= i_adj.neg;
        r_big[0]   <= n_big;
        r_den[0]   <= i_adj.den;
        r_v0[0]    <= i_adj.v0;
        r_rem[0]   <= i_adj.num;
        r_quo[0]   <= '0;
    end

    for (genvar s = 0; s < QB; s++) begin : g_stage
        localparam int K = QB - 1 - s;
        logic [2:0][VW-1:0] n_rem;
        logic [2:0][QB-1:0] n_quo;

        always_comb begin
            n_rem = r_rem[s];
            n_quo = r_quo[s];
            for (int j = 0; j < 3; j++) begin
                if ((r_rem[s][j] >> K) >= VW'(r_den[s])) begin
                    n_rem[j]    = r_rem[s][j] - (VW'(r_den[s]) << K);
                    n_quo[j][K] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s+1] <= 1'b0;
            end else begin
                r_valid[s+1] <= r_valid[s];
            end
            r_degen[s+1] <= r_degen[s];
            r_neg[s+1]   <= r_neg[s];
            r_big[s+1]   <= r_big[s];
            r_den[s+1]   <= r_den[s];
            r_v0[s+1]    <= r_v0[s];
            r_rem[s+1]   <= n_rem;
            r_quo[s+1]   <= n_quo;
        end
    end

    assign o_dout.valid = r_valid[QB];
    assign o_dout.degen = r_degen[QB];
    assign o_dout.neg   = r_neg[QB];
    assign o_dout.big   = r_big[QB];
    assign o_dout.quo   = r_quo[QB];
    assign o_dout.v0    = r_v0[QB];

endmodule

/* hw/rtl/tetrahedron_circumcenter_top.sv */
// top level of the tetrahedron circumcenter pipeline
//
// Takes four vertices on i_item when i_start is high and o_busy is low and
// returns the circumcenter on o_result, with o_done high for that one cycle.
// The result is a signed coordinate triple in the input units, rounded to
// nearest (ties away from zero), with status ok, degenerate (zero center)
// or overflow (clamped to the coordinate range).
// From the accepting edge to the edge that takes the result, an item passes
// through six stages of edge, product, cofactor and sum work, one range
// check, one restoring-divider stage per quotient bit (CoordBits + 1), and
// the output register.
// One item can be accepted every cycle; o_busy is low except in reset.
// Reset empties the pipeline and drops items in flight.
// The receiver cannot hold results off, so nothing in the pipeline stalls.
`include "assert_macros.svh"

module tetrahedron_circumcenter_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    output logic          o_busy,
    input  tcc_pkg::t_in  i_item,
    output logic          o_done,
    output tcc_pkg::t_out o_result
);

    localparam int C       = tcc_pkg::CoordBits;
    localparam int QB      = tcc_pkg::QuoBits;
    localparam int XW      = C + 3;
    localparam int Latency = QB + 8;

    logic            r_busy;
    logic            w_accept;
    tcc_pkg::t_front w_front;
    tcc_pkg::t_adj   w_adj;
    tcc_pkg::t_dout  w_dout;
    tcc_pkg::t_out   n_result;
    tcc_pkg::t_out   r_result;
    logic            r_done;
    logic [C-1:0]    w_ctr [3];
    logic [2:0]      w_sat;
    logic [XW-1:0]   w_sum [3];

    localparam logic [XW-1:0] Hi = XW'((1 << (C - 1)) - 1);
    localparam logic [XW-1:0] Lo = ~Hi;

    assign w_accept = i_start && !r_busy;

    tcc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_item  (i_item),
        .o_front (w_front)
    );

    tcc_adj u_adj (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_front (w_front),
        .o_adj   (w_adj)
    );

    tcc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adj   (w_adj),
        .o_dout  (w_dout)
    );

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_sum[j] = w_dout.neg[j]
                ? XW'($signed(w_dout.v0[j])) - XW'(w_dout.quo[j])
                : XW'($signed(w_dout.v0[j])) + XW'(w_dout.quo[j]);
            w_sat[j] = 1'b0;
            if (w_dout.big[j]) begin
                w_sat[j] = 1'b1;
                w_ctr[j] = w_dout.neg[j] ? Lo[C-1:0] : Hi[C-1:0];
            end else if ($signed(w_sum[j]) > $signed(Hi)) begin
                w_sat[j] = 1'b1;
                w_ctr[j] = Hi[C-1:0];
            end else if ($signed(w_sum[j]) < $signed(Lo)) begin
                w_sat[j] = 1'b1;
                w_ctr[j] = Lo[C-1:0];
            end else begin
                w_ctr[j] = w_sum[j][C-1:0];
            end
        end
        if (w_dout.degen) begin
            n_result.center_x = '0;
            n_result.center_y = '0;
            n_result.center_z = '0;
            n_result.status   = tcc_pkg::StatusDegenerate;
        end else begin
            n_result.center_x = w_ctr[0];
            n_result.center_y = w_ctr[1];
            n_result.center_z = w_ctr[2];
            n_result.status   = (w_sat != '0) ? tcc_pkg::StatusOverflow
                                              : tcc_pkg::StatusOk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else begin
            r_busy <= 1'b0;
            r_done <= w_dout.valid;
        end
        r_result <= n_result;
    end

    assign o_busy   = r_busy;
    assign o_done   = r_done;
    assign o_result = r_result;

    // every result traces back to an item taken a fixed time before
    `ASSERT_IMPL(a_done_latency, i_clk, i_rst_n, o_done, $past(w_accept, Latency))
    `ASSERT_IMPL(a_degen_zero, i_clk, i_rst_n,
        o_done && o_result.status == tcc_pkg::StatusDegenerate,
        o_result.center_x == '0 && o_result.center_y == '0 && o_result.center_z == '0)
    `ASSERT_CLK(a_no_busy_run, i_clk, i_rst_n, $past(i_rst_n) |-> !o_busy)

endmodule
